FILE: rtl/rss_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rss_pkg
// Shared types and constants of the string search core.
// ---------------------------------------------------------------------------
package rss_pkg;

  localparam int DEF_MAX_PATTERN = 32;
  localparam int DEF_ALPHABET    = 256;

  // width of the pattern length register, of shifts and step counters
  localparam int LEN_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 32;
  localparam int KIND_W  = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 72;

  // input item kinds
  localparam logic [KIND_W-1:0] KIND_PATTERN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

  // result kinds
  localparam logic RES_MATCH   = 1'b0;
  localparam logic RES_SUMMARY = 1'b1;

  // first comparison steps: last byte, middle byte, first byte
  localparam logic [LEN_W-1:0] STEP_LAST  = 6'd0;
  localparam logic [LEN_W-1:0] STEP_MID   = 6'd1;
  localparam logic [LEN_W-1:0] STEP_FIRST = 6'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REBUILD,
    ST_ALIGN,
    ST_CMP,
    ST_FIN,
    ST_SUM
  } state_t;

endpackage

FILE: rtl/rss_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rss_ram
// Simple dual-port RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
module rss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds when no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/raita_string_search_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// raita_string_search_core
// Horspool search with Raita comparison order over a byte stream.
// ---------------------------------------------------------------------------
// Usage: write the pattern length on the cfg channel, then send pattern
// words (in_tuser = 0) and text words (in_tuser = 1); in_tuser = 2 ends
// the text and returns a summary word with the match count and flags.
// Each full match returns a word carrying the alignment start and the
// running match count. out_tuser tells match (0) from summary (1).
// Timing: one item at a time, in_tready is low while an item is worked.
// A config write or a pattern word rebuilds the shift table, one pattern
// memory read per cycle. A stored text word passes the align state and,
// when an alignment ends there, the byte-at-a-time compare loop through
// the pattern and window memories and the finish state. An end-of-text
// word passes the summary state.
// The result sits in an output register; when the receiver stalls, the
// block finishes the item and waits only where it has a word to deliver.
// Reset (synchronous, rst_n low) clears the length, counters, flags and
// the shift-table valid bits; no clearing pass over memory is needed.
// ---------------------------------------------------------------------------
module raita_string_search_core #(
  parameter int MAX_PATTERN = rss_pkg::DEF_MAX_PATTERN,
  parameter int ALPHABET    = rss_pkg::DEF_ALPHABET
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration: pattern_length
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rss_pkg::LEN_W-1:0]       cfg_data,
  // input words
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rss_pkg::IN_DATA_W-1:0]   in_tdata,   // [7:0] byte_value
  input  logic [rss_pkg::KIND_W-1:0]      in_tuser,   // [1:0] kind
  // result words
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] position, [63:32] match_count, [64] length_error,
  // [65] text_overflow, [71:66] zero
  output logic [rss_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tuser   // [0] result_kind
);

  localparam int LEN_W = rss_pkg::LEN_W;
  localparam int POS_W = rss_pkg::POS_W;
  localparam int BW    = rss_pkg::BYTE_W;
  localparam int PI_W  = $clog2(MAX_PATTERN);
  localparam int LD_W  = $clog2(MAX_PATTERN + 1);
  localparam int AB_W  = $clog2(ALPHABET);
  localparam int IW    = ((PI_W > LEN_W) ? PI_W : LEN_W) + 1;

  rss_pkg::state_t state_r, state_nxt;

  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LD_W-1:0]     loaded_r, loaded_nxt;
  logic [ALPHABET-1:0] valid_r, valid_nxt;
  logic [POS_W-1:0]    tp_r, tp_nxt;
  logic [POS_W-1:0]    na_r, na_nxt;
  logic [POS_W-1:0]    found_r, found_nxt;
  logic                ovf_r, ovf_nxt;
  logic [PI_W-1:0]     wp_r, wp_nxt;
  logic [LEN_W-1:0]    i_r, i_nxt;
  logic [LEN_W-1:0]    wi_r, wi_nxt;
  logic [LEN_W-1:0]    s_r, s_nxt;
  logic                pend_r, pend_nxt;
  logic                last_r, last_nxt;
  logic                hit_r, hit_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;

  // payload registers
  logic [PI_W-1:0]     pidx_r, pidx_nxt;
  logic [PI_W-1:0]     start_r, start_nxt;
  logic [POS_W:0]      j_r, j_nxt;
  logic                svh_r, svh_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic [POS_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic                out_lerr_r, out_lerr_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  // memory ports
  logic            ps_we, ps_re;
  logic [PI_W-1:0] ps_waddr, ps_raddr;
  logic [BW-1:0]   ps_q;
  logic            wr_we, wr_re;
  logic [PI_W-1:0] wr_raddr;
  logic [BW-1:0]   wr_q;
  logic            st_we, st_re;
  logic [AB_W-1:0] st_waddr;
  logic [LEN_W-1:0] st_wdata, st_q;

  logic [LEN_W-1:0] m;
  logic             cfg_acc, in_acc;
  logic             out_free;
  logic             rb_more, align_go, cmp_miss, cmp_done, fin_commit;
  logic             pat_go, txt_go, txt_full;
  logic [LEN_W-1:0] k;
  logic [IW-1:0]    ring_sum, start_diff;
  logic [LEN_W-1:0] sh;
  logic [POS_W:0]   na_sum;

  // effective pattern length
  always_comb begin
    if (32'(len_r) > MAX_PATTERN) begin
      m = LEN_W'(MAX_PATTERN);
    end else begin
      m = len_r;
    end
  end

  assign cfg_ready = (state_r == rss_pkg::ST_IDLE);
  assign in_tready = (state_r == rss_pkg::ST_IDLE) && !cfg_valid;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  assign pat_go   = in_acc && (in_tuser == rss_pkg::KIND_PATTERN) &&
                    (loaded_r < LD_W'(MAX_PATTERN));
  assign txt_full = (tp_r == {POS_W{1'b1}});
  assign txt_go   = in_acc && (in_tuser == rss_pkg::KIND_TEXT) && !ovf_r && !txt_full;

  assign rb_more    = ({1'b0, i_r} + 7'd1) < {1'b0, m};
  assign align_go   = (m >= LEN_W'(2)) && !j_r[POS_W] && (j_r[POS_W-1:0] >= na_r);
  assign cmp_miss   = pend_r && (ps_q != wr_q);
  assign cmp_done   = pend_r && last_r;
  assign fin_commit = !hit_r || out_free;

  // offset inside the window for the current compare step
  always_comb begin
    case (s_r)
      rss_pkg::STEP_LAST:  k = m - LEN_W'(1);
      rss_pkg::STEP_MID:   k = m >> 1;
      rss_pkg::STEP_FIRST: k = '0;
      default:             k = s_r - LEN_W'(2);
    endcase
  end

  always_comb begin
    ring_sum = IW'(start_r) + IW'(k);
    if (ring_sum >= IW'(MAX_PATTERN)) begin
      ring_sum = ring_sum - IW'(MAX_PATTERN);
    end
  end

  // window start = slot of the newest byte minus (m - 1), modulo ring depth
  always_comb begin
    start_diff = IW'(pidx_r) - IW'(m - LEN_W'(1));
    if (start_diff[IW-1]) begin
      start_diff = start_diff + IW'(MAX_PATTERN);
    end
  end

  assign sh     = svh_r ? st_q : m;
  assign na_sum = {1'b0, j_r[POS_W-1:0]} + (POS_W+1)'(sh);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rss_pkg::ST_IDLE: begin
        if (cfg_acc || pat_go) begin
          state_nxt = rss_pkg::ST_REBUILD;
        end else if (txt_go) begin
          state_nxt = rss_pkg::ST_ALIGN;
        end else if (in_acc && (in_tuser == rss_pkg::KIND_END)) begin
          state_nxt = rss_pkg::ST_SUM;
        end
      end
      rss_pkg::ST_REBUILD: begin
        if (!rb_more && !pend_r) begin
          state_nxt = rss_pkg::ST_IDLE;
        end
      end
      rss_pkg::ST_ALIGN: begin
        state_nxt = align_go ? rss_pkg::ST_CMP : rss_pkg::ST_IDLE;
      end
      rss_pkg::ST_CMP: begin
        if (cmp_miss || cmp_done) begin
          state_nxt = rss_pkg::ST_FIN;
        end
      end
      rss_pkg::ST_FIN: begin
        if (fin_commit) begin
          state_nxt = rss_pkg::ST_IDLE;
        end
      end
      rss_pkg::ST_SUM: begin
        if (out_free) begin
          state_nxt = rss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rss_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    len_nxt      = len_r;
    loaded_nxt   = loaded_r;
    valid_nxt    = valid_r;
    tp_nxt       = tp_r;
    na_nxt       = na_r;
    found_nxt    = found_r;
    ovf_nxt      = ovf_r;
    wp_nxt       = wp_r;
    i_nxt        = i_r;
    wi_nxt       = wi_r;
    s_nxt        = s_r;
    pend_nxt     = pend_r;
    last_nxt     = last_r;
    hit_nxt      = hit_r;
    pidx_nxt     = pidx_r;
    start_nxt    = start_r;
    j_nxt        = j_r;
    svh_nxt      = svh_r;
    out_kind_nxt = out_kind_r;
    out_pos_nxt  = out_pos_r;
    out_cnt_nxt  = out_cnt_r;
    out_lerr_nxt = out_lerr_r;
    out_ovf_nxt  = out_ovf_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    ps_we    = 1'b0;
    ps_waddr = PI_W'(loaded_r);
    ps_re    = 1'b0;
    ps_raddr = PI_W'(i_r);
    wr_we    = 1'b0;
    wr_re    = 1'b0;
    wr_raddr = PI_W'(ring_sum);
    st_we    = 1'b0;
    st_waddr = AB_W'(ps_q);
    st_wdata = m - LEN_W'(1) - wi_r;
    st_re    = 1'b0;

    case (state_r)
      rss_pkg::ST_IDLE: begin
        if (cfg_acc) begin
          len_nxt    = cfg_data;
          loaded_nxt = '0;
          valid_nxt  = '0;
          i_nxt      = '0;
          pend_nxt   = 1'b0;
        end else if (pat_go) begin
          ps_we      = 1'b1;
          loaded_nxt = loaded_r + LD_W'(1);
          valid_nxt  = '0;
          i_nxt      = '0;
          pend_nxt   = 1'b0;
        end else if (in_acc && (in_tuser == rss_pkg::KIND_TEXT) && !ovf_r) begin
          if (txt_full) begin
            ovf_nxt = 1'b1;
          end else begin
            wr_we    = 1'b1;
            st_re    = 1'b1;
            tp_nxt   = tp_r + POS_W'(1);
            pidx_nxt = wp_r;
            wp_nxt   = (wp_r == PI_W'(MAX_PATTERN - 1)) ? '0 : wp_r + PI_W'(1);
            j_nxt    = {1'b0, tp_r} + (POS_W+1)'(1) - (POS_W+1)'(m);
            svh_nxt  = ((BW+1)'(in_tdata) < (BW+1)'(ALPHABET)) &&
                       valid_r[AB_W'(in_tdata)];
          end
        end
      end
      rss_pkg::ST_REBUILD: begin
        // write the entry read in the previous cycle, later indexes win
        if (pend_r && ((BW+1)'(ps_q) < (BW+1)'(ALPHABET))) begin
          st_we = 1'b1;
          valid_nxt[AB_W'(ps_q)] = 1'b1;
        end
        if (rb_more) begin
          ps_re    = 1'b1;
          wi_nxt   = i_r;
          i_nxt    = i_r + LEN_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      rss_pkg::ST_ALIGN: begin
        start_nxt = PI_W'(start_diff);
        s_nxt     = rss_pkg::STEP_LAST;
        pend_nxt  = 1'b0;
        last_nxt  = 1'b0;
      end
      rss_pkg::ST_CMP: begin
        ps_raddr = PI_W'(k);
        if (cmp_miss) begin
          hit_nxt  = 1'b0;
          pend_nxt = 1'b0;
        end else if (cmp_done) begin
          hit_nxt  = 1'b1;
          pend_nxt = 1'b0;
        end else begin
          ps_re    = 1'b1;
          wr_re    = 1'b1;
          pend_nxt = 1'b1;
          last_nxt = (s_r == m);
          s_nxt    = s_r + LEN_W'(1);
        end
      end
      rss_pkg::ST_FIN: begin
        if (fin_commit) begin
          na_nxt = na_sum[POS_W] ? {POS_W{1'b1}} : na_sum[POS_W-1:0];
          if (hit_r) begin
            if (found_r != {POS_W{1'b1}}) begin
              found_nxt = found_r + POS_W'(1);
              out_cnt_nxt = found_r + POS_W'(1);
            end else begin
              out_cnt_nxt = found_r;
            end
            out_kind_nxt   = rss_pkg::RES_MATCH;
            out_pos_nxt    = j_r[POS_W-1:0];
            out_lerr_nxt   = 1'b0;
            out_ovf_nxt    = 1'b0;
            out_tvalid_nxt = 1'b1;
          end
        end
      end
      rss_pkg::ST_SUM: begin
        if (out_free) begin
          out_kind_nxt   = rss_pkg::RES_SUMMARY;
          out_pos_nxt    = '0;
          out_cnt_nxt    = found_r;
          out_lerr_nxt   = (m < LEN_W'(2));
          out_ovf_nxt    = ovf_r;
          out_tvalid_nxt = 1'b1;
          tp_nxt    = '0;
          na_nxt    = '0;
          found_nxt = '0;
          ovf_nxt   = 1'b0;
          wp_nxt    = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rss_pkg::ST_IDLE;
      len_r        <= '0;
      loaded_r     <= '0;
      valid_r      <= '0;
      tp_r         <= '0;
      na_r         <= '0;
      found_r      <= '0;
      ovf_r        <= 1'b0;
      wp_r         <= '0;
      i_r          <= '0;
      wi_r         <= '0;
      s_r          <= '0;
      pend_r       <= 1'b0;
      last_r       <= 1'b0;
      hit_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      len_r        <= len_nxt;
      loaded_r     <= loaded_nxt;
      valid_r      <= valid_nxt;
      tp_r         <= tp_nxt;
      na_r         <= na_nxt;
      found_r      <= found_nxt;
      ovf_r        <= ovf_nxt;
      wp_r         <= wp_nxt;
      i_r          <= i_nxt;
      wi_r         <= wi_nxt;
      s_r          <= s_nxt;
      pend_r       <= pend_nxt;
      last_r       <= last_nxt;
      hit_r        <= hit_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r     <= pidx_nxt;
    start_r    <= start_nxt;
    j_r        <= j_nxt;
    svh_r      <= svh_nxt;
    out_kind_r <= out_kind_nxt;
    out_pos_r  <= out_pos_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_lerr_r <= out_lerr_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  rss_ram #(
    .WIDTH (BW),
    .DEPTH (MAX_PATTERN)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (ps_we),
    .waddr (ps_waddr),
    .wdata (in_tdata),
    .re    (ps_re),
    .raddr (ps_raddr),
    .rdata (ps_q)
  );

  rss_ram #(
    .WIDTH (BW),
    .DEPTH (MAX_PATTERN)
  ) u_window_ram (
    .clk   (clk),
    .we    (wr_we),
    .waddr (wp_r),
    .wdata (in_tdata),
    .re    (wr_re),
    .raddr (wr_raddr),
    .rdata (wr_q)
  );

  rss_ram #(
    .WIDTH (LEN_W),
    .DEPTH (ALPHABET)
  ) u_shift_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (AB_W'(in_tdata)),
    .rdata (st_q)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {6'b0, out_ovf_r, out_lerr_r, out_cnt_r, out_pos_r};

  // a length write invalidates every shift entry before the rebuild
  a_cfg_clears_table: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> (valid_r == '0))
    else $error("shift valid bits not cleared on length write");

  // the alignment only moves forward while a text byte is finished
  a_alignment_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rss_pkg::ST_FIN) |=> (na_r >= $past(na_r)))
    else $error("next alignment moved backward");

  // a summary loaded into the output register restarts the text counters
  a_summary_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == rss_pkg::ST_SUM) && out_free) |=>
      ((tp_r == '0) && (found_r == '0) && !ovf_r && out_tvalid_r))
    else $error("text state not cleared after summary");

  // ring write pointer stays inside the window memory
  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wp_r) < MAX_PATTERN)
    else $error("window pointer out of range");

endmodule

FILE: test/tb_raita_string_search_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_raita_string_search_core
// Self-checking bench for the Horspool/Raita string search core.
// A short scripted run covers the length error, the smallest pattern, byte
// extremes, the unused kind and a length change in the middle of a text.
// Random search sessions follow, each with its own length, pattern and text,
// with random idles on both stream sides but none in the last phase. Every
// result word is compared field by field with a bit-accurate model kept here.
// ---------------------------------------------------------------------------
module tb_raita_string_search_core;

  localparam int          PAT_SLOTS     = rss_pkg::DEF_MAX_PATTERN;
  localparam int          SETTLE_CYCLES = 48;
  localparam int          CYCLE_LIMIT   = 500000;
  localparam logic [1:0]  KIND_UNUSED   = 2'd3;

  typedef struct packed {
    logic        rkind;
    logic [31:0] pos;
    logic [31:0] cnt;
    logic        lerr;
    logic        ovf;
  } report_t;

  typedef enum logic [0:0] {ROW_LENGTH, ROW_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t  what;
    logic [1:0] kind;
    logic [7:0] value;   // byte for a word, pattern length for a length write
    logic       typed;
    report_t    want;
  } script_row_t;

  localparam report_t NO_REPORT  = '0;
  localparam report_t EMPTY_LERR = '{rss_pkg::RES_SUMMARY, 32'd0, 32'd0, 1'b1, 1'b0};

  localparam int SCRIPT_ROWS = 23;
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    // length zero right after reset: empty summary flagged as length error
    '{ROW_WORD,   rss_pkg::KIND_END,     8'h00, 1'b1, EMPTY_LERR},
    '{ROW_LENGTH, rss_pkg::KIND_PATTERN, 8'd1,  1'b0, NO_REPORT},
    // single-byte pattern: text is counted, never searched
    '{ROW_WORD,   rss_pkg::KIND_TEXT,    8'h00, 1'b0, NO_REPORT},
    '{ROW_WORD,   rss_pkg::KIND_END,     8'h00, 1'b1, EMPTY_LERR},
    '{ROW_LENGTH, rss_pkg::KIND_PATTERN, 8'd2,  1'b0, NO_REPORT},
    '{ROW_WORD,   rss_pkg::KIND_PATTERN, 8'hFF, 1'b0, NO_REPORT},
    '{ROW_WORD,   rss_pkg::KIND_PATTERN, 8'h00, 1'b0, NO_REPORT},
    '{ROW_WORD,   rss_pkg::KIND_TEXT,    8'hFF, 1'b0, NO_REPORT},
    '{ROW_WORD,   rss_pkg::KIND_TEXT,    8'h00, 1'b0, NO_REPORT},
    '{ROW_WORD,   KIND_UNUSED,           8'hA5, 1'b0, NO_REPORT},
    '{ROW_WORD,   rss_pkg::KIND_TEXT,    8'hFF, 1'b0, NO_REPORT},
    '{ROW_WORD,   rss_pkg::KIND_TEXT,    8'h00, 1'b0, NO_REPORT},
    '{ROW_WORD,   rss_pkg::KIND_TEXT,    8'hFF, 1'b0, NO_REPORT},
    '{ROW_WORD,   rss_pkg::KIND_TEXT,    8'hFF, 1'b0, NO_REPORT},
    '{ROW_WORD,   rss_pkg::KIND_TEXT,    8'h00, 1'b0, NO_REPORT},
    '{ROW_WORD,   rss_pkg::KIND_END,     8'hFF, 1'b0, NO_REPORT},
    // length drops to one and comes back while the text runs on
    '{ROW_WORD,   rss_pkg::KIND_TEXT,    8'hFF, 1'b0, NO_REPORT},
    '{ROW_LENGTH, rss_pkg::KIND_PATTERN, 8'd1,  1'b0, NO_REPORT},
    '{ROW_WORD,   rss_pkg::KIND_TEXT,    8'h00, 1'b0, NO_REPORT},
    '{ROW_LENGTH, rss_pkg::KIND_PATTERN, 8'd2,  1'b0, NO_REPORT},
    '{ROW_WORD,   rss_pkg::KIND_TEXT,    8'hFF, 1'b0, NO_REPORT},
    '{ROW_WORD,   rss_pkg::KIND_TEXT,    8'h00, 1'b0, NO_REPORT},
    '{ROW_WORD,   rss_pkg::KIND_END,     8'h00, 1'b0, NO_REPORT}
  };

  logic                            clk         = 1'b0;
  logic                            rst_n       = 1'b0;
  logic                            cfg_valid   = 1'b0;
  logic                            cfg_ready;
  logic [rss_pkg::LEN_W-1:0]       cfg_data    = '0;
  logic                            in_tvalid   = 1'b0;
  logic                            in_tready;
  logic [rss_pkg::IN_DATA_W-1:0]   in_tdata    = '0;   // [7:0] byte_value
  logic [rss_pkg::KIND_W-1:0]      in_tuser    = '0;   // [1:0] kind
  logic                            out_tvalid;
  logic                            out_tready  = 1'b0;
  // [31:0] position, [63:32] match_count, [64] length_error, [65] text_overflow
  logic [rss_pkg::OUT_DATA_W-1:0]  out_tdata;
  logic                            out_tuser;          // [0] result_kind

  raita_string_search_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // search model state
  bit [5:0]    len_reg;
  bit [7:0]    pat_mem [PAT_SLOTS];
  int unsigned shift_by [256];
  bit          shift_ok [256];
  int unsigned pat_loaded;
  int unsigned filled_hi;     // pattern entries written since reset
  bit [7:0]    win_mem [PAT_SLOTS];
  bit [31:0]   text_pos;
  bit [31:0]   align_at;
  bit [31:0]   hit_count;
  bit          text_ovf;

  report_t     reports_due [$];
  int unsigned sender_idle;
  int unsigned receiver_idle;
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned sessions;
  int unsigned length_writes;
  int unsigned match_words;
  int unsigned summary_words;
  int unsigned cycle_count;

  function automatic int unsigned used_length();
    return (len_reg > PAT_SLOTS) ? PAT_SLOTS : int'(len_reg);
  endfunction

  function automatic void refresh_shifts();
    int unsigned m;
    m = used_length();
    shift_ok = '{default: 1'b0};
    for (int unsigned i = 0; i + 1 < m; i++) begin
      shift_by[pat_mem[i]] = m - i - 1;
      shift_ok[pat_mem[i]] = 1'b1;
    end
  endfunction

  function automatic void set_length(input logic [5:0] v);
    len_reg = v;
    pat_loaded = 0;
    refresh_shifts();
  endfunction

  // one accepted input word; returns 1 with the result word it causes
  function automatic bit advance_search(input logic [1:0] kind, input logic [7:0] b,
                                        output report_t rep);
    int unsigned     m;
    longint unsigned at, j, nxt;
    bit              hit;
    m = used_length();
    rep = '0;
    case (kind)
      rss_pkg::KIND_PATTERN: begin
        if (pat_loaded < PAT_SLOTS) begin
          pat_mem[pat_loaded] = b;
          pat_loaded++;
          if (pat_loaded > filled_hi) filled_hi = pat_loaded;
          refresh_shifts();
        end
        return 1'b0;
      end
      rss_pkg::KIND_TEXT: begin
        if (text_ovf) return 1'b0;
        if (text_pos == 32'hFFFF_FFFF) begin
          text_ovf = 1'b1;
          return 1'b0;
        end
        at = text_pos;
        text_pos++;
        win_mem[at % PAT_SLOTS] = b;
        if (m < 2 || at + 1 < m) return 1'b0;
        j = at + 1 - m;
        if (j < align_at) return 1'b0;
        hit = 1'b1;
        for (int unsigned k = 0; k < m; k++)
          if (pat_mem[k] != win_mem[(j + k) % PAT_SLOTS]) hit = 1'b0;
        if (hit && hit_count != 32'hFFFF_FFFF) hit_count++;
        nxt = j + (shift_ok[b] ? shift_by[b] : m);
        align_at = (nxt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nxt[31:0];
        if (!hit) return 1'b0;
        rep.rkind = rss_pkg::RES_MATCH;
        rep.pos   = j[31:0];
        rep.cnt   = hit_count;
        return 1'b1;
      end
      rss_pkg::KIND_END: begin
        rep.rkind = rss_pkg::RES_SUMMARY;
        rep.cnt   = hit_count;
        rep.lerr  = (m < 2);
        rep.ovf   = text_ovf;
        text_pos  = '0;
        align_at  = '0;
        hit_count = '0;
        text_ovf  = 1'b0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [7:0] b,
                           input bit typed, input report_t want);
    report_t rep;
    while ($urandom_range(99) < sender_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (advance_search(kind, b, rep)) reports_due.push_back(typed ? want : rep);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  // only while idle: all results in, then the block's longest busy spell
  task automatic write_length(input logic [5:0] v);
    in_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    set_length(v);
    length_writes++;
  endtask

  // a length, a pattern, a text with planted copies and length writes, a summary
  task automatic run_session();
    int unsigned len_val, m, n_pat, n_txt, sent, abc_n, r, flip, i;
    logic [7:0]  abc [4];
    case ($urandom_range(9))
      0:       len_val = 0;
      1:       len_val = 1;
      2:       len_val = 2;
      3:       len_val = 32;
      4:       len_val = 63;
      5:       len_val = $urandom_range(33, 63);
      default: len_val = $urandom_range(3, 12);
    endcase
    write_length(6'(len_val));
    m = used_length();
    abc_n = $urandom_range(2, 4);
    for (i = 0; i < 4; i++) abc[i] = 8'($urandom_range(255));
    if (m < 2) n_pat = $urandom_range(0, 2);
    else n_pat = m + (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
    for (i = 0; i < n_pat; i++)
      send_item(rss_pkg::KIND_PATTERN, ($urandom_range(11) == 0) ? 8'($urandom_range(255))
                : abc[$urandom_range(abc_n - 1)], 1'b0, NO_REPORT);
    n_txt = $urandom_range(m + 4, 2 * m + 24);
    sent = 0;
    while (sent < n_txt) begin
      r = $urandom_range(99);
      if (r < 30 && m < 2) r = 50;
      if (r < 30) begin
        // planted copy of the pattern, now and then with one byte redrawn
        flip = ($urandom_range(2) == 0) ? $urandom_range(m - 1) : m;
        for (i = 0; i < m; i++)
          send_item(rss_pkg::KIND_TEXT,
                    (i == flip) ? abc[$urandom_range(abc_n - 1)] : pat_mem[i],
                    1'b0, NO_REPORT);
        sent += m;
      end else if (r < 34) begin
        send_item(2'($urandom_range(3)), 8'($urandom_range(255)), 1'b0, NO_REPORT);
        sent++;
      end else if (r < 36) begin
        // new length mid-text, within the pattern entries already written
        write_length(6'($urandom_range(0, filled_hi)));
        m = used_length();
      end else begin
        send_item(rss_pkg::KIND_TEXT, ($urandom_range(19) == 0) ? 8'($urandom_range(255))
                  : abc[$urandom_range(abc_n - 1)], 1'b0, NO_REPORT);
        sent++;
      end
    end
    send_item(rss_pkg::KIND_END, 8'($urandom_range(255)), 1'b0, NO_REPORT);
    sessions++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (reports_due.size() == 0) begin
          $error("result word with nothing expected: kind %0d position %0h count %0h",
                 out_tuser, out_tdata[31:0], out_tdata[63:32]);
          mismatch_count++;
        end else begin
          want = reports_due.pop_front();
          check_field("result_kind", 32'(want.rkind), 32'(out_tuser));
          check_field("position", want.pos, out_tdata[31:0]);
          check_field("match_count", want.cnt, out_tdata[63:32]);
          check_field("length_error", 32'(want.lerr), 32'(out_tdata[64]));
          check_field("text_overflow", 32'(want.ovf), 32'(out_tdata[65]));
          if (want.rkind == rss_pkg::RES_MATCH) match_words++;
          else summary_words++;
        end
      end
      out_tready <= ($urandom_range(99) >= receiver_idle);
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, reports_due.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    int          r;
    int unsigned phase, target;
    sender_idle   = 37;
    receiver_idle = 60;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < SCRIPT_ROWS; r++) begin
      if (SCRIPT[r].what == ROW_LENGTH) write_length(SCRIPT[r].value[5:0]);
      else send_item(SCRIPT[r].kind, SCRIPT[r].value, SCRIPT[r].typed, SCRIPT[r].want);
    end

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin sender_idle = 37; receiver_idle = 60; end
        1:       begin sender_idle = 60; receiver_idle = 37; end
        default: begin sender_idle = 0;  receiver_idle = 0;  end
      endcase
      target = items_sent + 150;
      while (items_sent < target) run_session();
    end

    in_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d input words over %0d search sessions with %0d length writes",
             items_sent, sessions, length_writes);
    $display("compared %0d match words and %0d summary words, %0d mismatches",
             match_words, summary_words, mismatch_count);
    if (mismatch_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/rss_pkg.sv
rtl/rss_ram.sv
rtl/raita_string_search_core.sv
test/tb_raita_string_search_core.sv
